// ===== rtl/core/hbvt_pkg.sv =====
// ----------------------------------------------------------------------------
// hbvt_pkg
// Shared constants, types and score arithmetic for the four-state tagger.
// ----------------------------------------------------------------------------
package hbvt_pkg;

  // sizing
  localparam int MAX_LEN    = 64;
  localparam int EMIT_BITS  = 16;
  localparam int SCORE_BITS = 24;
  localparam int FIELD_BITS = 16;
  localparam int NSTATE     = 4;
  localparam int TAG_BITS   = 2;
  localparam int POS_BITS   = 6;
  localparam int CNT_BITS   = $clog2(MAX_LEN + 1);
  localparam int ADDR_BITS  = $clog2(MAX_LEN);
  localparam int PTR_BITS   = NSTATE * TAG_BITS;
  localparam int CFG_BITS   = NSTATE * FIELD_BITS;
  localparam int IDX_BITS   = 3;
  localparam int IN_BITS    = ((NSTATE * EMIT_BITS + 7) / 8) * 8;
  localparam int OUT_BITS   = ((TAG_BITS + POS_BITS + 7) / 8) * 8;
  localparam int SUM_BITS   = ((SCORE_BITS > EMIT_BITS) ? SCORE_BITS : EMIT_BITS) + 2;

  // types
  typedef logic signed [SCORE_BITS-1:0] score_t;
  typedef logic signed [EMIT_BITS-1:0]  emit_t;
  typedef logic signed [SUM_BITS-1:0]   sum_t;
  typedef logic [TAG_BITS-1:0]          tag_t;

  // tag codes
  localparam tag_t TAG_B = 2'd0;
  localparam tag_t TAG_E = 2'd1;
  localparam tag_t TAG_M = 2'd2;
  localparam tag_t TAG_S = 2'd3;

  // register indexes
  localparam logic [IDX_BITS-1:0] REG_START   = 3'd0;
  localparam logic [IDX_BITS-1:0] REG_TRANS_B = 3'd1;
  localparam logic [IDX_BITS-1:0] REG_TRANS_E = 3'd2;
  localparam logic [IDX_BITS-1:0] REG_TRANS_M = 3'd3;
  localparam logic [IDX_BITS-1:0] REG_TRANS_S = 3'd4;

  // score limits, minimum means impossible
  localparam score_t SCORE_MIN = {1'b1, {(SCORE_BITS-1){1'b0}}};
  localparam score_t SCORE_MAX = {1'b0, {(SCORE_BITS-1){1'b1}}};
  localparam sum_t   SAT_LO    = {{(SUM_BITS-SCORE_BITS){1'b1}}, SCORE_MIN};
  localparam sum_t   SAT_HI    = {{(SUM_BITS-SCORE_BITS){1'b0}}, SCORE_MAX};

  // clamp a wide sum into the score range
  function automatic score_t sat_score(input sum_t v);
    score_t r;
    if (v < SAT_LO) begin
      r = SCORE_MIN;
    end else if (v > SAT_HI) begin
      r = SCORE_MAX;
    end else begin
      r = v[SCORE_BITS-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/hbvt_ram.sv =====
// ----------------------------------------------------------------------------
// hbvt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hbvt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/hmm_bems_viterbi_tagger.sv =====
// ----------------------------------------------------------------------------
// hmm_bems_viterbi_tagger
// Four-state (B, E, M, S) log-domain Viterbi decoder with traceback.
// ----------------------------------------------------------------------------
// One character item is taken while the decoder is idle; it is accepted and
// then makes four passes of the single add-compare-select unit, one pass per
// destination state. When the item closes a sentence (tlast, or MAX_LEN
// characters), the end state is picked and each tag then takes a back
// pointer RAM read, then the output item, which waits while the output side
// stalls. Tags come out last position first; the tag for position zero carries
// tlast. No clearing pass is needed after reset.
module hmm_bems_viterbi_tagger (
  input  logic                            clk,
  input  logic                            rst,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [hbvt_pkg::IDX_BITS-1:0]   cfg_index,
  input  logic [hbvt_pkg::CFG_BITS-1:0]   cfg_data,
  // character items in
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [hbvt_pkg::IN_BITS-1:0]    s_axis_tdata,  // emit_b, emit_e, emit_m, emit_s
  input  logic                            s_axis_tlast,  // last
  // tag items out
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [hbvt_pkg::OUT_BITS-1:0]   m_axis_tdata,  // tag, position
  output logic                            m_axis_tlast   // final_res
);

  import hbvt_pkg::*;

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ACS    = 3'd1;
  localparam logic [2:0] S_END    = 3'd2;
  localparam logic [2:0] S_TB_RD  = 3'd3;
  localparam logic [2:0] S_TB_OUT = 3'd4;

  logic [2:0]            state;
  logic [TAG_BITS-1:0]   dst;
  logic [CNT_BITS-1:0]   char_count;
  logic [CNT_BITS-1:0]   count_inc;
  score_t                path [NSTATE];
  score_t                next_sc [NSTATE];
  logic [PTR_BITS-1:0]   ptrs;
  emit_t                 emit_r [NSTATE];
  logic                  last_r;
  tag_t                  cur;
  logic [ADDR_BITS-1:0]  pos;

  logic [CFG_BITS-1:0]   start_r;
  logic [CFG_BITS-1:0]   trans_r [NSTATE];

  score_t                cand [NSTATE];
  score_t                init_sc;
  score_t                win_lo;
  score_t                win_hi;
  tag_t                  arg_lo;
  tag_t                  arg_hi;
  score_t                best;
  tag_t                  best_arg;

  logic                  bp_wr_en;
  logic                  bp_rd_en;
  logic [PTR_BITS-1:0]   bp_rd_data;
  logic                  out_fire;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_r <= '0;
      for (int k = 0; k < NSTATE; k++) begin
        trans_r[k] <= '0;
      end
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_START:   start_r    <= cfg_data;
        REG_TRANS_B: trans_r[0] <= cfg_data;
        REG_TRANS_E: trans_r[1] <= cfg_data;
        REG_TRANS_M: trans_r[2] <= cfg_data;
        REG_TRANS_S: trans_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // shared add-compare-select unit for destination state dst
  always_comb begin
    sum_t tr;
    sum_t em;
    em = SUM_BITS'(emit_r[dst]);
    for (int p = 0; p < NSTATE; p++) begin
      tr = SUM_BITS'($signed(trans_r[p][FIELD_BITS*dst +: FIELD_BITS]));
      if (path[p] == SCORE_MIN) begin
        cand[p] = SCORE_MIN;
      end else begin
        cand[p] = sat_score(SUM_BITS'(path[p]) + tr + em);
      end
    end
    init_sc = sat_score(SUM_BITS'($signed(start_r[FIELD_BITS*dst +: FIELD_BITS])) + em);
    // pairwise compare, the lower source keeps a tie
    if (cand[1] > cand[0]) begin
      win_lo = cand[1];
      arg_lo = TAG_E;
    end else begin
      win_lo = cand[0];
      arg_lo = TAG_B;
    end
    if (cand[3] > cand[2]) begin
      win_hi = cand[3];
      arg_hi = TAG_S;
    end else begin
      win_hi = cand[2];
      arg_hi = TAG_M;
    end
    if (win_hi > win_lo) begin
      best     = win_hi;
      best_arg = arg_hi;
    end else begin
      best     = win_lo;
      best_arg = arg_lo;
    end
    // nothing beats impossible: pointer defaults to E
    if (best == SCORE_MIN) begin
      best_arg = TAG_E;
    end
  end

  assign count_inc = char_count + 1'b1;
  assign out_fire  = m_axis_tvalid && m_axis_tready;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      dst        <= '0;
      char_count <= '0;
      for (int k = 0; k < NSTATE; k++) begin
        path[k] <= SCORE_MIN;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            dst   <= '0;
            state <= S_ACS;
          end
        end
        S_ACS: begin
          if (char_count == '0) begin
            next_sc[dst] <= init_sc;
          end else begin
            next_sc[dst] <= best;
          end
          ptrs[TAG_BITS*dst +: TAG_BITS] <= best_arg;
          dst <= dst + 1'b1;
          if (dst == TAG_S) begin
            path[0] <= next_sc[0];
            path[1] <= next_sc[1];
            path[2] <= next_sc[2];
            path[3] <= (char_count == '0) ? init_sc : best;
            char_count <= count_inc;
            if (last_r || count_inc == CNT_BITS'(MAX_LEN)) begin
              state <= S_END;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_END: begin
          cur   <= (path[TAG_E] < path[TAG_S]) ? TAG_S : TAG_E;
          pos   <= ADDR_BITS'(char_count - 1'b1);
          state <= S_TB_RD;
        end
        S_TB_RD: begin
          state <= S_TB_OUT;
        end
        S_TB_OUT: begin
          if (out_fire) begin
            if (pos == '0) begin
              char_count <= '0;
              for (int k = 0; k < NSTATE; k++) begin
                path[k] <= SCORE_MIN;
              end
              state <= S_IDLE;
            end else begin
              cur   <= bp_rd_data[TAG_BITS*cur +: TAG_BITS];
              pos   <= pos - 1'b1;
              state <= S_TB_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // input item capture
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      for (int k = 0; k < NSTATE; k++) begin
        emit_r[k] <= s_axis_tdata[EMIT_BITS*k +: EMIT_BITS];
      end
      last_r <= s_axis_tlast;
    end
  end

  // back pointer store, one entry of four pointers per character after the first
  assign bp_wr_en = (state == S_ACS) && (dst == TAG_S) && (char_count != '0);
  assign bp_rd_en = (state == S_TB_RD);

  hbvt_ram #(
    .WIDTH (PTR_BITS),
    .DEPTH (MAX_LEN)
  ) u_bp_ram (
    .clk     (clk),
    .wr_en   (bp_wr_en),
    .wr_addr (ADDR_BITS'(char_count)),
    .wr_data ({best_arg, ptrs[PTR_BITS-TAG_BITS-1:0]}),
    .rd_en   (bp_rd_en),
    .rd_addr (pos),
    .rd_data (bp_rd_data)
  );

  // handshakes and result item
  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_TB_OUT);
  assign m_axis_tdata  = OUT_BITS'({POS_BITS'(pos), cur});
  assign m_axis_tlast  = (pos == '0);

  // checks
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !m_axis_tvalid)
    else $error("input taken while a tag is pending");

  a_run_cleared: assert property (@(posedge clk) disable iff (rst)
    (out_fire && m_axis_tlast) |=> (char_count == '0 && s_axis_tready))
    else $error("run not cleared after final tag");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    char_count <= CNT_BITS'(MAX_LEN))
    else $error("character count beyond limit");

  a_pos_step: assert property (@(posedge clk) disable iff (rst)
    (out_fire && !m_axis_tlast) |=> ##1
      (m_axis_tvalid && m_axis_tdata[7:2] == $past(m_axis_tdata[7:2], 2) - 6'd1))
    else $error("traceback position did not step down by one");

endmodule
